/* rtl/wfps_pkg.sv */
`default_nettype none
package wfps_pkg;

  localparam int unsigned DistW  = 8;
  localparam int unsigned SpeedW = 7;
  localparam int unsigned DriveW = 9;
  localparam int unsigned SteerW = 8;
  localparam int unsigned GainW  = 3;
  localparam int unsigned NumW   = 18;

  localparam logic [DistW-1:0]  FarLimit   = 8'd50;
  localparam logic [DistW-1:0]  NearDist   = 8'd30;
  localparam logic [DistW-1:0]  StopDist   = 8'd13;
  localparam logic [SpeedW-1:0] SpeedReset = 7'd30;

  localparam logic signed [6:0] TargetDist = 7'sd36;
  localparam logic signed [6:0] FarProp    = 7'sd5;
  localparam logic signed [8:0] IntegLimit = 9'sd100;
  localparam logic signed [SteerW-1:0] TurnThresh = -8'sd2;
  localparam logic [6:0]  SteerMax   = 7'd127;
  // |n| at or above this gives |n/20| above the steering limit
  localparam logic [16:0] SatMag     = 17'd2560;
  // ceil(2^16/20); exact quotient for |n| below SatMag
  localparam logic [11:0] RecipTwenty = 12'd3277;

  // proportional gain base_speed/20, settled once per register write
  function automatic logic [GainW-1:0] gain_of(input logic [SpeedW-1:0] s);
    logic [GainW-1:0] g;
    g = 3'd0;
    if (s >= 7'd120)     g = 3'd6;
    else if (s >= 7'd100) g = 3'd5;
    else if (s >= 7'd80)  g = 3'd4;
    else if (s >= 7'd60)  g = 3'd3;
    else if (s >= 7'd40)  g = 3'd2;
    else if (s >= 7'd20)  g = 3'd1;
    return g;
  endfunction

endpackage
`default_nettype wire

/* rtl/wfps_if.sv */
`default_nettype none
interface wfps_in_if;
  import wfps_pkg::*;
  logic              valid;
  logic              ready;
  logic [DistW-1:0]  left_distance;
  logic [DistW-1:0]  right_distance;
  modport source (output valid, left_distance, right_distance, input ready);
  modport sink   (input valid, left_distance, right_distance, output ready);
endinterface

interface wfps_out_if;
  import wfps_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DriveW-1:0] left_drive;
  logic signed [DriveW-1:0] right_drive;
  logic signed [SteerW-1:0] steer_value;
  logic                     stop;
  modport source (output valid, left_drive, right_drive, steer_value, stop, input ready);
  modport sink   (input valid, left_drive, right_drive, steer_value, stop, output ready);
endinterface

interface wfps_cfg_if;
  import wfps_pkg::*;
  logic              valid;
  logic              ready;
  logic [SpeedW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

/* rtl/wall_follow_pid_steering.sv */
// An accepted input beat passes through stage 1, stage 2 and the result register to out_ch.
// Throughput: one beat per cycle while out_ch is ready; the integral and previous-left
//   state close their loop within the middle stage.
// Reset (rst_n low, synchronous): all stages empty, previous left and
//   integral cleared to 0, base speed back to 30. cfg_ch is always ready.
`default_nettype none
module wall_follow_pid_steering
  import wfps_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  wfps_in_if.sink     in_ch,
  wfps_out_if.source  out_ch,
  wfps_cfg_if.sink    cfg_ch
);

  // configuration: speed and its derived gain
  logic [SpeedW-1:0] base_speed_r;
  logic [GainW-1:0]  gain_r;

  // stage 1: captured sample pair
  logic              s1_valid_r;
  logic [DistW-1:0]  s1_left_r;
  logic [DistW-1:0]  s1_right_r;

  // stage 2: numerator of the steering term, right sample carried along
  logic                   s2_valid_r;
  logic signed [NumW-1:0] s2_num_r;
  logic [DistW-1:0]       s2_right_r;

  // loop state
  logic [DistW-1:0]   prev_left_r;
  logic signed [7:0]  integral_r;

  // result register
  logic                     out_valid_r;
  logic signed [DriveW-1:0] left_drive_r;
  logic signed [DriveW-1:0] right_drive_r;
  logic signed [SteerW-1:0] steer_r;
  logic                     stop_r;

  // stall chain: a stage advances when it is empty or the one after advances
  logic adv3, adv2, adv1;
  assign adv3 = !out_valid_r || out_ch.ready;
  assign adv2 = !s2_valid_r  || adv3;
  assign adv1 = !s1_valid_r  || adv2;

  assign in_ch.ready  = adv1;
  assign cfg_ch.ready = 1'b1;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_speed_r <= SpeedReset;
      gain_r       <= gain_of(SpeedReset);
    end else if (cfg_ch.valid) begin
      base_speed_r <= cfg_ch.data;
      gain_r       <= gain_of(cfg_ch.data);
    end
  end

  // ---------------- stage 1 ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv1) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_ch.valid) begin
      s1_left_r  <= in_ch.left_distance;
      s1_right_r <= in_ch.right_distance;
    end
  end

  // ---------------- stage 2: PID terms ----------------
  logic                   far;
  logic signed [6:0]      prop;
  logic signed [9:0]      deriv;
  logic signed [8:0]      isum;
  logic signed [7:0]      integral_nxt;
  logic signed [9:0]      prop_gain;
  logic signed [14:0]     deriv_ext;
  logic signed [14:0]     inner;
  logic signed [NumW-1:0] inner_ext;
  logic signed [NumW-1:0] num_nxt;
  logic [DistW-1:0]       prev_left_nxt;

  always_comb begin
    far = s1_left_r > FarLimit;
    // beyond the far limit the wall is lost: fixed push, no derivative
    if (far) begin
      prop  = FarProp;
      deriv = 10'sd0;
    end else begin
      prop  = $signed({1'b0, s1_left_r[5:0]}) - TargetDist;
      deriv = $signed({2'b00, s1_left_r}) - $signed({2'b00, prev_left_r});
    end

    // integral resets to zero once it leaves +/-100
    isum = {integral_r[7], integral_r} + {{2{prop[6]}}, prop};
    if (isum > IntegLimit || isum < -IntegLimit) begin
      integral_nxt = 8'sd0;
    end else begin
      integral_nxt = isum[7:0];
    end

    // gain is 0..6: a tiny multiply
    prop_gain = {{3{prop[6]}}, prop} * $signed({7'd0, gain_r});
    deriv_ext = {{5{deriv[9]}}, deriv};
    // 30*d as 32*d - 2*d
    inner     = {{5{prop_gain[9]}}, prop_gain} + (deriv_ext <<< 5) - (deriv_ext <<< 1);
    inner_ext = {{(NumW-15){inner[14]}}, inner};
    // n = 10*inner + I, as 8*inner + 2*inner + I
    num_nxt   = (inner_ext <<< 3) + (inner_ext <<< 1)
              + {{(NumW-8){integral_nxt[7]}}, integral_nxt};
    prev_left_nxt = s1_left_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      prev_left_r <= '0;
      integral_r  <= '0;
    end else if (adv2) begin
      s2_valid_r <= s1_valid_r;
      // advance the loop state only on a real beat
      if (s1_valid_r) begin
        prev_left_r <= prev_left_nxt;
        integral_r  <= integral_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid_r) begin
      s2_num_r   <= num_nxt;
      s2_right_r <= s1_right_r;
    end
  end

  // ---------------- stage 3: divide, clamp, drive select ----------------
  logic                     neg;
  logic [NumW-1:0]          mag;
  logic                     sat;
  logic [23:0]              quot_prod;
  logic [6:0]               steer_mag;
  logic signed [SteerW-1:0] steer_nxt;
  logic signed [DriveW-1:0] steer_ext;
  logic signed [DriveW-1:0] speed_ext;
  logic signed [DriveW-1:0] left_drive_nxt;
  logic signed [DriveW-1:0] right_drive_nxt;
  logic                     stop_nxt;

  always_comb begin
    // truncation toward zero: divide the magnitude, restore the sign
    neg       = s2_num_r[NumW-1];
    mag       = neg ? NumW'(-s2_num_r) : NumW'(s2_num_r);
    sat       = mag[16:0] >= SatMag;
    quot_prod = mag[11:0] * RecipTwenty;
    steer_mag = sat ? SteerMax : quot_prod[22:16];
    steer_nxt = neg ? -$signed({1'b0, steer_mag}) : $signed({1'b0, steer_mag});

    steer_ext = {steer_nxt[SteerW-1], steer_nxt};
    speed_ext = $signed({2'b00, base_speed_r});
    stop_nxt  = s2_right_r <= StopDist;

    priority if (stop_nxt) begin
      left_drive_nxt  = '0;
      right_drive_nxt = '0;
    end else if (s2_right_r < NearDist) begin
      // obstacle close ahead: creep at the distance reading
      left_drive_nxt  = $signed({1'b0, s2_right_r});
      right_drive_nxt = $signed({1'b0, s2_right_r});
    end else if (steer_nxt < TurnThresh) begin
      left_drive_nxt  = speed_ext - steer_ext;
      right_drive_nxt = speed_ext;
    end else begin
      left_drive_nxt  = speed_ext;
      right_drive_nxt = speed_ext + steer_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv3) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && s2_valid_r) begin
      left_drive_r  <= left_drive_nxt;
      right_drive_r <= right_drive_nxt;
      steer_r       <= steer_nxt;
      stop_r        <= stop_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.left_drive  = left_drive_r;
  assign out_ch.right_drive = right_drive_r;
  assign out_ch.steer_value = steer_r;
  assign out_ch.stop        = stop_r;

endmodule
`default_nettype wire

/* rtl/wfps_checker.sv */
`default_nettype none
module wfps_checker
  import wfps_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic signed [DriveW-1:0] out_left_drive,
  input wire logic signed [DriveW-1:0] out_right_drive,
  input wire logic signed [SteerW-1:0] out_steer_value,
  input wire logic                     out_stop
);

  // a pending result beat is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  // stop forces both drives to zero
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stop |-> out_left_drive == '0 && out_right_drive == '0)
    else $error("drives not zero on stop");

  // steering stays within the symmetric clamp
  a_steer_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_steer_value != -8'sd128)
    else $error("steer outside clamp");

  // with no result waiting, the pipeline takes a new beat
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind wall_follow_pid_steering wfps_checker u_wfps_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_left_drive  (out_ch.left_drive),
  .out_right_drive (out_ch.right_drive),
  .out_steer_value (out_ch.steer_value),
  .out_stop        (out_ch.stop)
);
`default_nettype wire
